// File: hdl/aes_block_cipher_assert.svh
// Assertion macros used by the AES cipher top module, aes_block_cipher.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef AES_BLOCK_CIPHER_ASSERT_SVH
`define AES_BLOCK_CIPHER_ASSERT_SVH

// implication checked every clock, off in reset
`define AES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AES_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/aes_pkg.sv
// AES package: payload structs, config indexes, S-box and round functions.
// Used by every module of the AES block cipher; no dependencies.
`default_nettype none
package aes_pkg;

    localparam int NumStages = 15;

    localparam logic [2:0] CfgKeySize  = 3'd0;
    localparam logic [2:0] CfgKeyWord0 = 3'd1;
    localparam logic [2:0] CfgKeyWord1 = 3'd2;
    localparam logic [2:0] CfgKeyWord2 = 3'd3;
    localparam logic [2:0] CfgKeyWord3 = 3'd4;

    localparam logic CmdEncrypt = 1'b0;
    localparam logic CmdDecrypt = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } aes_out_t;

    typedef struct packed {
        logic         vld;
        logic         cmd;
        logic [127:0] state;
    } aes_stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [3:0] PERM [16] = '{
        4'd0,4'd5,4'd10,4'd15,4'd4,4'd9,4'd14,4'd3,
        4'd8,4'd13,4'd2,4'd7,4'd12,4'd1,4'd6,4'd11
    };

    function automatic logic [7:0] sbox_inv(input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (SBOX[i] == b) begin
                r = 8'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i sits at bits 127-8i
    function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (inv) begin
                r[127 - 8*PERM[i] -: 8] = sbox_inv(get_b(s, i));
            end else begin
                r[127 - 8*i -: 8] = SBOX[get_b(s, PERM[i])];
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [7:0] a0, a1, a2, a3, t, u, v, xh;
        r = s;
        for (int c = 0; c < 16; c += 4) begin
            a0 = get_b(s, c);
            a1 = get_b(s, c+1);
            a2 = get_b(s, c+2);
            a3 = get_b(s, c+3);
            t = a0 ^ a1 ^ a2 ^ a3;
            u = 8'h00;
            v = 8'h00;
            if (inv) begin
                xh = xt(t);
                u = xt(xt(xh ^ a0 ^ a2));
                v = xt(xt(xh ^ a1 ^ a3));
            end
            r[127 - 8*c -: 8]     = a0 ^ t ^ u ^ xt(a0 ^ a1);
            r[127 - 8*(c+1) -: 8] = a1 ^ t ^ v ^ xt(a1 ^ a2);
            r[127 - 8*(c+2) -: 8] = a2 ^ t ^ u ^ xt(a2 ^ a3);
            r[127 - 8*(c+3) -: 8] = a3 ^ t ^ v ^ xt(a3 ^ a0);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/aes_key_sched.sv
// Registered AES key expansion: one 32-bit word per cycle after each key write.
// Depends on aes_pkg. Produces all 15 round keys, held until the next write.
`default_nettype none
module aes_key_sched (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_wdata,
    output logic [3:0]        rounds,
    output logic [1919:0]     round_keys,
    output logic              key_ready
);
    import aes_pkg::*;

    logic [1:0]   ksize_reg;
    logic [255:0] key_reg;
    logic [31:0]  w_reg [60];
    logic [5:0]   idx_reg;
    logic [7:0]   rcon_reg;
    logic [3:0]   nk;
    logic [5:0]   cnt_reg;
    logic [31:0]  tmp, prev, newv;
    logic         at_nk;

    always_comb begin
        if (ksize_reg[1]) begin
            nk = 4'd8;
            rounds = 4'd14;
        end else if (ksize_reg[0]) begin
            nk = 4'd6;
            rounds = 4'd12;
        end else begin
            nk = 4'd4;
            rounds = 4'd10;
        end
    end

    assign key_ready = (idx_reg == 6'd60);

    // cnt_reg = idx mod nk once idx reaches nk
    assign prev  = w_reg[idx_reg - 6'd1];
    assign at_nk = (cnt_reg == 6'd0);
    always_comb begin
        tmp = prev;
        if (at_nk) begin
            tmp = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_reg, 24'h0};
        end else if (nk == 4'd8 && cnt_reg == 6'd4) begin
            tmp = sub_word(prev);
        end
        newv = w_reg[idx_reg - 6'({2'b00, nk})] ^ tmp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksize_reg <= 2'd0;
            key_reg   <= '0;
            idx_reg   <= 6'd0;
            cnt_reg   <= 6'd0;
            rcon_reg  <= 8'h01;
        end else if (cfg_we) begin
            case (cfg_index)
                CfgKeySize:  ksize_reg <= cfg_wdata[1:0];
                CfgKeyWord0: key_reg[255:192] <= cfg_wdata;
                CfgKeyWord1: key_reg[191:128] <= cfg_wdata;
                CfgKeyWord2: key_reg[127:64]  <= cfg_wdata;
                CfgKeyWord3: key_reg[63:0]    <= cfg_wdata;
                default: ;
            endcase
            idx_reg  <= 6'd0;
            cnt_reg  <= 6'd0;
            rcon_reg <= 8'h01;
        end else if (idx_reg < 6'({2'b00, nk})) begin
            idx_reg <= idx_reg + 6'd1;
        end else if (idx_reg < 6'd60) begin
            idx_reg <= idx_reg + 6'd1;
            cnt_reg <= (cnt_reg + 6'd1 == 6'({2'b00, nk})) ? 6'd0 : cnt_reg + 6'd1;
            if (at_nk) begin
                rcon_reg <= xt(rcon_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (idx_reg < 6'({2'b00, nk})) begin
            w_reg[idx_reg[5:0]] <= key_reg[255 - 32*idx_reg[2:0] -: 32];
        end else if (idx_reg < 6'd60) begin
            w_reg[idx_reg[5:0]] <= newv;
        end
    end

    always_comb begin
        for (int i = 0; i < 60; i++) begin
            round_keys[1919 - 32*i -: 32] = w_reg[i];
        end
    end
endmodule
`default_nettype wire

// File: hdl/aes_round.sv
// One pipelined AES round stage, encrypt or inverse direction per beat.
// Depends on aes_pkg. Stage index selects the round keys it applies.
`default_nettype none
module aes_round (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic [3:0]         stage,
    input  wire logic [3:0]         rounds,
    input  wire logic [1919:0]      round_keys,
    input  wire aes_pkg::aes_stage_t d_in,
    output aes_pkg::aes_stage_t      d_out
);
    import aes_pkg::*;

    aes_stage_t   q_reg;
    aes_stage_t   q_next;
    logic [127:0] s, rk_e, rk_d, rk_f;
    logic         act, last;

    function automatic logic [127:0] rk(input logic [1919:0] k, input logic [3:0] r);
        return k[1919 - 128*r -: 128];
    endfunction

    // stage 0 is the initial AddRoundKey; stage r in 1..rounds is round r; others pass
    always_comb begin
        act  = (stage <= rounds);
        last = (stage == rounds);
        rk_e = rk(round_keys, stage);
        rk_d = rk(round_keys, rounds - stage);
        s = d_in.state;
        if (stage == 4'd0) begin
            s = s ^ (d_in.cmd ? rk(round_keys, rounds) : rk_e);
        end else if (act) begin
            if (d_in.cmd == CmdEncrypt) begin
                s = sub_shift(s, 1'b0);
                if (!last) begin
                    s = mix_cols(s, 1'b0);
                end
                s = s ^ rk_e;
            end else begin
                s = sub_shift(s, 1'b1);
                s = s ^ rk_d;
                if (!last) begin
                    s = mix_cols(s, 1'b1);
                end
            end
        end
        rk_f = '0;
        q_next.vld   = d_in.vld;
        q_next.cmd   = d_in.cmd;
        q_next.state = s ^ rk_f;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.vld <= 1'b0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;
endmodule
`default_nettype wire

// File: hdl/aes_block_cipher.sv
// AES-128/192/256 cipher: 15 register stages, one beat per cycle when not stalled.
// Stage 0 adds the first round key; stage r does round r; unused stages pass through.
// Throughput one block per cycle; a stall holds every stage.
// A key write reruns the expansion, holding s_ready low until it ends; reset does too.
// Reset (aresetn, synchronous, low) clears valid bits and sets an all-zero 128-bit key.
`default_nettype none
module aes_block_cipher (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [63:0]      cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire aes_pkg::aes_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output aes_pkg::aes_out_t     m_data
);
    import aes_pkg::*;

    logic [3:0]    rounds;
    logic [1919:0] round_keys;
    logic          key_ready;
    aes_stage_t    st [NumStages + 1];
    logic          en;

    aes_key_sched u_ks (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .rounds(rounds), .round_keys(round_keys),
        .key_ready(key_ready)
    );

    assign en = m_ready || !st[NumStages].vld;
    assign s_ready = en && key_ready;
    assign st[0].vld   = s_valid && key_ready;
    assign st[0].cmd   = s_data.cmd;
    assign st[0].state = {s_data.block_hi, s_data.block_lo};

    for (genvar g = 0; g < NumStages; g++) begin : g_rnd
        aes_round u_rnd (
            .aclk(aclk), .aresetn(aresetn), .en(en), .stage(4'(g)),
            .rounds(rounds), .round_keys(round_keys), .d_in(st[g]), .d_out(st[g+1])
        );
    end

    assign m_valid = st[NumStages].vld;
    assign m_data.result_hi = st[NumStages].state[127:64];
    assign m_data.result_lo = st[NumStages].state[63:0];

`include "aes_block_cipher_assert.svh"
    `AES_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `AES_ASSERT_IMP(a_ready_free, aclk, aresetn, !m_valid && key_ready, s_ready)
    `AES_ASSERT_NXT(a_flow, aclk, aresetn, en && st[NumStages-1].vld, m_valid)
endmodule
`default_nettype wire
